>>> hw/rtl/adcm_pkg.sv
// ----------------------------------------------------------------------------
// adcm_pkg
// Shared types and constants for the two-wire sigma-delta adc master.
// ----------------------------------------------------------------------------
package adcm_pkg;

  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned RDATA_W      = 24;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned ELAPSED_W    = 17;
  localparam int unsigned TIMEOUT_W    = 16;
  localparam int unsigned LEAD_PULSES  = 27;
  localparam int unsigned SYNC_PULSES  = 2;
  localparam int unsigned CMD_PULSES   = 7;
  localparam int unsigned DATA_PULSES  = 8;

  localparam logic [6:0]           CMD_READ      = 7'h56;
  localparam logic [6:0]           CMD_WRITE     = 7'h65;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;

  // apb register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] REG_TIMEOUT_ADDR = 3'd0;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_RCFG   = 2'd2,
    OP_WCFG   = 2'd3
  } op_e;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_WAIT_HIGH = 9'b000000010,
    PH_WAIT_LOW  = 9'b000000100,
    PH_LEAD      = 9'b000001000,
    PH_SYNC      = 9'b000010000,
    PH_CMD       = 9'b000100000,
    PH_TURN      = 9'b001000000,
    PH_DATA      = 9'b010000000,
    PH_FINAL     = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] wdata;
    logic       din;
    logic       ms_tick;
  } item_t;

  typedef struct packed {
    logic               timed_out;
    logic [RDATA_W-1:0] rdata;
    logic               done_res;
    logic               busy_res;
    logic               sda_drive;
    logic               sda_out;
    logic               sclk;
  } res_t;

endpackage

>>> hw/rtl/adc_two_wire_serial_master_unit.sv
// ----------------------------------------------------------------------------
// adc_two_wire_serial_master_unit
// Output: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while m_axis is not back-pressured; every beat is one half-clock slot handled in
// a single pass of the slot sequencer, with one output register toward m_axis.
// Reset: asynchronous active low; idle, line released, timeout_ms back to 100.
// ----------------------------------------------------------------------------
module adc_two_wire_serial_master_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // func[1:0], wdata[9:2], din[10], ms_tick[11]
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // sclk[0], sda_out[1], sda_drive[2],
                                                           // busy_res[3], done_res[4],
                                                           // rdata[28:5], timed_out[29]
  // apb config
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [adcm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import adcm_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_q;
  item_t                item;
  res_t                 res;
  res_t                 res_q;
  logic                 out_valid_q;
  logic                 step;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TIMEOUT_ADDR) ? {16'd0, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_TIMEOUT_ADDR)) begin
      timeout_q <= pwdata[TIMEOUT_W-1:0];
    end
  end

  // input beat unpack
  assign item.func    = s_axis_tdata[1:0];
  assign item.wdata   = s_axis_tdata[9:2];
  assign item.din     = s_axis_tdata[10];
  assign item.ms_tick = s_axis_tdata[11];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  adcm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (item),
    .timeout_ms_i (timeout_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.timed_out, res_q.rdata, res_q.done_res,
                          res_q.busy_res, res_q.sda_drive, res_q.sda_out, res_q.sclk};

endmodule

>>> hw/rtl/adcm_core.sv
// ----------------------------------------------------------------------------
// adcm_core
// Slot sequencer: advances the transfer state by one half-clock slot per
// accepted beat and forms that slot's pin levels and status.
// ----------------------------------------------------------------------------
module adcm_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  adcm_pkg::item_t                      item_i,
  input  logic [adcm_pkg::TIMEOUT_W-1:0]       timeout_ms_i,
  output adcm_pkg::res_t                       res_o
);
  import adcm_pkg::*;

  phase_e                 phase_q, phase_d;
  op_e                    op_q, op_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_inc, plen;
  logic                   half_q, half_d;
  logic [RDATA_W-1:0]     shift_q, shift_d;
  logic [7:0]             byte_q, byte_d;
  logic [6:0]             cmd_q, cmd_d;
  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic                   tseen_q, tseen_d;
  logic                   lvl_q, lvl_d;
  logic                   en_q, en_d;
  logic                   busy, done, sclk, sample_now;
  logic [RDATA_W-1:0]     rdata;

  always_comb begin
    case (phase_q)
      PH_LEAD:  plen = (op_q == OP_SAMPLE) ? CNT_W'(SAMPLE_BITS) : CNT_W'(LEAD_PULSES);
      PH_SYNC:  plen = CNT_W'(SYNC_PULSES);
      PH_CMD:   plen = CNT_W'(CMD_PULSES);
      PH_DATA:  plen = CNT_W'(DATA_PULSES);
      default:  plen = CNT_W'(1);
    endcase
  end

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign sample_now = ((phase_q == PH_LEAD) && (op_q == OP_SAMPLE)) ||
                      ((phase_q == PH_DATA) && (op_q != OP_WCFG));

  always_comb begin
    phase_d   = phase_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    half_d    = half_q;
    shift_d   = shift_q;
    byte_d    = byte_q;
    cmd_d     = cmd_q;
    elapsed_d = elapsed_q;
    tseen_d   = tseen_q;
    lvl_d     = lvl_q;
    en_d      = en_q;
    busy      = 1'b1;
    done      = 1'b0;
    sclk      = 1'b0;
    rdata     = '0;

    case (phase_q)
      PH_IDLE: begin
        lvl_d = 1'b1;
        en_d  = 1'b0;
        busy  = 1'b0;
        if (op_e'(item_i.func) != OP_NONE) begin
          op_d      = op_e'(item_i.func);
          byte_d    = item_i.wdata;
          cmd_d     = (op_e'(item_i.func) == OP_WCFG) ? CMD_WRITE : CMD_READ;
          shift_d   = '0;
          elapsed_d = '0;
          tseen_d   = 1'b0;
          cnt_d     = '0;
          half_d    = 1'b0;
          phase_d   = PH_WAIT_HIGH;
          busy      = 1'b1;
        end
      end
      PH_WAIT_HIGH, PH_WAIT_LOW: begin
        lvl_d = 1'b1;
        en_d  = 1'b0;
        if (item_i.ms_tick && (elapsed_q != ELAPSED_MAX)) begin
          elapsed_d = elapsed_q + ELAPSED_W'(1);
        end
        // a line change in this slot wins over the timeout
        if ((phase_q == PH_WAIT_HIGH) && item_i.din) begin
          phase_d = PH_WAIT_LOW;
        end else if ((phase_q == PH_WAIT_LOW) && !item_i.din) begin
          phase_d = PH_LEAD;
        end else if (elapsed_d > {1'b0, timeout_ms_i}) begin
          tseen_d = 1'b1;
          phase_d = PH_LEAD;
        end
        cnt_d  = '0;
        half_d = 1'b0;
      end
      PH_LEAD, PH_SYNC, PH_CMD, PH_TURN, PH_DATA, PH_FINAL: begin
        if (!half_q) begin
          // high half: set the data line for this pulse
          case (phase_q)
            PH_SYNC: begin en_d = 1'b1; lvl_d = 1'b1; end
            PH_CMD:  begin en_d = 1'b1; lvl_d = cmd_q[6]; end
            PH_TURN: begin en_d = (op_q == OP_WCFG); lvl_d = 1'b1; end
            PH_DATA: begin
              en_d  = (op_q == OP_WCFG);
              lvl_d = (op_q == OP_WCFG) ? byte_q[7] : 1'b1;
            end
            PH_FINAL: begin en_d = 1'b1; lvl_d = 1'b1; end
            default: begin en_d = 1'b0; lvl_d = 1'b1; end
          endcase
          sclk   = 1'b1;
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (sample_now) begin
            shift_d = {shift_q[RDATA_W-2:0], item_i.din};
          end
          if (phase_q == PH_CMD) begin
            cmd_d = {cmd_q[5:0], 1'b0};
          end
          if ((phase_q == PH_DATA) && (op_q == OP_WCFG)) begin
            byte_d = {byte_q[6:0], 1'b0};
          end
          if (cnt_inc >= plen) begin
            cnt_d = '0;
            if (((phase_q == PH_LEAD) && (op_q == OP_SAMPLE)) || (phase_q == PH_FINAL)) begin
              done    = 1'b1;
              rdata   = (op_q == OP_WCFG) ? '0 : shift_d;
              phase_d = PH_IDLE;
            end else begin
              case (phase_q)
                PH_LEAD: phase_d = PH_SYNC;
                PH_SYNC: phase_d = PH_CMD;
                PH_CMD:  phase_d = PH_TURN;
                PH_TURN: phase_d = PH_DATA;
                PH_DATA: phase_d = PH_FINAL;
                default: phase_d = PH_IDLE;
              endcase
            end
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        busy    = 1'b0;
        lvl_d   = 1'b1;
        en_d    = 1'b0;
      end
    endcase

    res_o.sclk      = sclk;
    res_o.sda_out   = lvl_d;
    res_o.sda_drive = en_d;
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.rdata     = rdata;
    res_o.timed_out = busy & tseen_d;

    // release the line once the transfer is over
    if (done) begin
      lvl_d = 1'b1;
      en_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      op_q      <= OP_NONE;
      cnt_q     <= '0;
      half_q    <= 1'b0;
      shift_q   <= '0;
      byte_q    <= '0;
      cmd_q     <= '0;
      elapsed_q <= '0;
      tseen_q   <= 1'b0;
      lvl_q     <= 1'b1;
      en_q      <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      op_q      <= op_d;
      cnt_q     <= cnt_d;
      half_q    <= half_d;
      shift_q   <= shift_d;
      byte_q    <= byte_d;
      cmd_q     <= cmd_d;
      elapsed_q <= elapsed_d;
      tseen_q   <= tseen_d;
      lvl_q     <= lvl_d;
      en_q      <= en_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PH_IDLE) && (op_e'(item_i.func) == OP_NONE) |=> phase_q == PH_IDLE)
    else $error("idle left without a request");

  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> (phase_q == PH_IDLE) && !en_q && lvl_q)
    else $error("line not released after done");

  a_half_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> !((phase_q == PH_IDLE) || (phase_q == PH_WAIT_HIGH) ||
                 (phase_q == PH_WAIT_LOW)))
    else $error("half flag set outside a pulse phase");

  a_elapsed_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ((phase_q == PH_WAIT_HIGH) || (phase_q == PH_WAIT_LOW)) && !item_i.ms_tick
    |=> $stable(elapsed_q))
    else $error("ms count moved without a tick");
`endif

endmodule

>>> tb/adc_two_wire_serial_master_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_two_wire_serial_master_unit_tb
// Drives the adc master one half-clock slot per stream beat and checks every
// output beat against a slot-accurate model of the pin sequencer. A short
// table covers all requests, both data extremes and both ready-wait timeouts.
// Random transfers follow with well-formed ready handshakes, broken and noisy
// sequences, under several timeout register settings.
// ----------------------------------------------------------------------------
module adc_two_wire_serial_master_unit_tb;
  import adcm_pkg::*;

  localparam int unsigned SAMPLE_SLOTS   = 2 * SAMPLE_BITS;
  localparam int unsigned CFG_SLOTS      =
    2 * (LEAD_PULSES + SYNC_PULSES + CMD_PULSES + 1 + DATA_PULSES + 1);
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SLOTS_PER_SET  = 40;

  localparam res_t IDLE_PINS = '{timed_out: 1'b0, rdata: '0, done_res: 1'b0,
                                 busy_res: 1'b0, sda_drive: 1'b0, sda_out: 1'b1,
                                 sclk: 1'b0};
  localparam res_t REQ_PINS  = '{timed_out: 1'b0, rdata: '0, done_res: 1'b0,
                                 busy_res: 1'b1, sda_drive: 1'b0, sda_out: 1'b1,
                                 sclk: 1'b0};

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  wdata;
    logic        din;
    logic        tick;
    int unsigned reps;
    logic        pinned;
    res_t        want;
  } vec_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // func[1:0], wdata[9:2], din[10], ms_tick[11]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;        // sclk[0], sda_out[1], sda_drive[2], busy_res[3],
                                              // done_res[4], rdata[28:5], timed_out[29]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  adc_two_wire_serial_master_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10ns clk_i = ~clk_i;

  // pin sequencer model state
  logic [TIMEOUT_W-1:0] tmo_ms;
  phase_e               seq_phase;
  logic [CNT_W-1:0]     pulse_idx;
  logic                 in_low_half;
  logic [RDATA_W-1:0]   rx_shift;
  op_e                  cur_op;
  logic [7:0]           tx_byte;
  logic [6:0]           cmd_shift;
  logic [ELAPSED_W-1:0] wait_ms;
  logic                 wait_expired;
  logic                 clk_level;
  logic                 line_level;
  logic                 line_drive;

  res_t        pending_pins[$];
  vec_row_t    vec_rows[$];
  logic        pin_fixed = 1'b0;
  res_t        pin_fixed_val = '0;
  int unsigned errors = 0;
  int unsigned sent_slots = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  function automatic void reset_pin_model();
    tmo_ms       = TIMEOUT_RESET;
    seq_phase    = PH_IDLE;
    pulse_idx    = '0;
    in_low_half  = 1'b0;
    rx_shift     = '0;
    cur_op       = OP_NONE;
    tx_byte      = '0;
    cmd_shift    = '0;
    wait_ms      = '0;
    wait_expired = 1'b0;
    clk_level    = 1'b0;
    line_level   = 1'b1;
    line_drive   = 1'b0;
  endfunction

  function automatic int unsigned pulses_in(phase_e p);
    case (p)
      PH_LEAD: return (cur_op == OP_SAMPLE) ? SAMPLE_BITS : LEAD_PULSES;
      PH_SYNC: return SYNC_PULSES;
      PH_CMD:  return CMD_PULSES;
      PH_DATA: return DATA_PULSES;
      default: return 1;
    endcase
  endfunction

  function automatic phase_e phase_after(phase_e p);
    case (p)
      PH_LEAD: return PH_SYNC;
      PH_SYNC: return PH_CMD;
      PH_CMD:  return PH_TURN;
      PH_TURN: return PH_DATA;
      PH_DATA: return PH_FINAL;
      default: return PH_IDLE;
    endcase
  endfunction

  // line levels are set up at the rising half of each pulse
  function automatic void set_line_for_pulse();
    line_drive = 1'b0;
    line_level = 1'b1;
    case (seq_phase)
      PH_SYNC, PH_FINAL: line_drive = 1'b1;
      PH_CMD: begin
        line_drive = 1'b1;
        line_level = cmd_shift[6];
      end
      PH_TURN: line_drive = (cur_op == OP_WCFG);
      PH_DATA: begin
        if (cur_op == OP_WCFG) begin
          line_drive = 1'b1;
          line_level = tx_byte[7];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic res_t advance_slot(item_t it);
    res_t               pins;
    logic               busy;
    logic               done;
    logic [RDATA_W-1:0] word;
    busy = 1'b1;
    done = 1'b0;
    word = '0;
    case (seq_phase)
      PH_IDLE: begin
        clk_level  = 1'b0;
        line_drive = 1'b0;
        line_level = 1'b1;
        busy       = 1'b0;
        if (it.func != OP_NONE) begin
          cur_op       = op_e'(it.func);
          tx_byte      = it.wdata;
          cmd_shift    = (it.func == OP_WCFG) ? CMD_WRITE : CMD_READ;
          rx_shift     = '0;
          wait_ms      = '0;
          wait_expired = 1'b0;
          pulse_idx    = '0;
          in_low_half  = 1'b0;
          seq_phase    = PH_WAIT_HIGH;
          busy         = 1'b1;
        end
      end
      PH_WAIT_HIGH, PH_WAIT_LOW: begin
        clk_level  = 1'b0;
        line_drive = 1'b0;
        line_level = 1'b1;
        if (it.ms_tick && wait_ms != ELAPSED_MAX) wait_ms = wait_ms + 1'b1;
        // a line edge in this slot wins over the timeout
        if (seq_phase == PH_WAIT_HIGH && it.din) begin
          seq_phase = PH_WAIT_LOW;
        end else if (seq_phase == PH_WAIT_LOW && !it.din) begin
          seq_phase = PH_LEAD;
        end else if (wait_ms > tmo_ms) begin
          wait_expired = 1'b1;
          seq_phase    = PH_LEAD;
        end
        pulse_idx   = '0;
        in_low_half = 1'b0;
      end
      default: begin
        if (!in_low_half) begin
          set_line_for_pulse();
          clk_level   = 1'b1;
          in_low_half = 1'b1;
        end else begin
          clk_level   = 1'b0;
          in_low_half = 1'b0;
          if ((seq_phase == PH_LEAD && cur_op == OP_SAMPLE) ||
              (seq_phase == PH_DATA && cur_op != OP_WCFG))
            rx_shift = {rx_shift[RDATA_W-2:0], it.din};
          if (seq_phase == PH_CMD) cmd_shift = cmd_shift << 1;
          if (seq_phase == PH_DATA && cur_op == OP_WCFG) tx_byte = tx_byte << 1;
          pulse_idx = pulse_idx + 1'b1;
          if (pulse_idx >= pulses_in(seq_phase)) begin
            pulse_idx = '0;
            if ((seq_phase == PH_LEAD && cur_op == OP_SAMPLE) || seq_phase == PH_FINAL) begin
              done      = 1'b1;
              word      = (cur_op == OP_WCFG) ? '0 : rx_shift;
              seq_phase = PH_IDLE;
            end else begin
              seq_phase = phase_after(seq_phase);
            end
          end
        end
      end
    endcase
    pins.sclk      = clk_level;
    pins.sda_out   = line_level;
    pins.sda_drive = line_drive;
    pins.busy_res  = busy;
    pins.done_res  = done;
    pins.rdata     = word;
    pins.timed_out = busy & wait_expired;
    // the line is released right after the finishing slot
    if (done) begin
      line_drive = 1'b0;
      line_level = 1'b1;
    end
    return pins;
  endfunction

  function automatic void cmp_field(string name, logic [RDATA_W-1:0] want,
                                    logic [RDATA_W-1:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      errors++;
    end
  endfunction

  // model runs on input beats, output beats are checked in order
  always @(posedge clk_i) begin
    item_t it;
    res_t  calc;
    res_t  want;
    res_t  seen;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.func    = s_axis_tdata[1:0];
        it.wdata   = s_axis_tdata[9:2];
        it.din     = s_axis_tdata[10];
        it.ms_tick = s_axis_tdata[11];
        calc = advance_slot(it);
        pending_pins.push_back(pin_fixed ? pin_fixed_val : calc);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = res_t'(m_axis_tdata[29:0]);
        if (pending_pins.size() == 0) begin
          $error("output beat 0x%0h with no slot pending", m_axis_tdata);
          errors++;
        end else begin
          want = pending_pins.pop_front();
          cmp_field("sclk", want.sclk, seen.sclk);
          cmp_field("sda_out", want.sda_out, seen.sda_out);
          cmp_field("sda_drive", want.sda_drive, seen.sda_drive);
          cmp_field("busy_res", want.busy_res, seen.busy_res);
          cmp_field("done_res", want.done_res, seen.done_res);
          cmp_field("rdata", want.rdata, seen.rdata);
          cmp_field("timed_out", want.timed_out, seen.timed_out);
        end
      end
    end
  end

  // receiver stall pattern, mode redrawn at random from four patterns
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rx_cycle % 8 != 5);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_slot(input logic [1:0] f, input logic [7:0] wd, input logic d,
                           input logic t, input logic fixed, input res_t fixed_val);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, t, d, wd, f};
    pin_fixed     <= fixed;
    pin_fixed_val <= fixed_val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_slots++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pins.size() != 0) @(posedge clk_i);
  endtask

  // finish any transfer in progress so the register can be written
  task automatic bring_to_idle();
    drain_results();
    while (seq_phase != PH_IDLE) begin
      send_slot(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
      drain_results();
    end
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TIMEOUT_ADDR;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tmo_ms = val;
    // read back
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= REG_TIMEOUT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(val)) begin
      $error("timeout_ms readback: expected 0x%0h, got 0x%0h", val, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_row(input logic [1:0] f, input logic [7:0] wd, input logic d,
                         input logic t, input int unsigned reps, input logic fixed,
                         input res_t fixed_val);
    vec_row_t row;
    row.func   = f;
    row.wdata  = wd;
    row.din    = d;
    row.tick   = t;
    row.reps   = reps;
    row.pinned = fixed;
    row.want   = fixed_val;
    vec_rows.push_back(row);
  endtask

  task automatic build_vectors();
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, 2, 1'b1, IDLE_PINS);
    add_row(OP_NONE, 8'hff, 1'b1, 1'b1, 2, 1'b1, IDLE_PINS);
    // sample read, all ones, new requests ignored while busy
    add_row(OP_SAMPLE, 8'h00, 1'b0, 1'b0, 1, 1'b1, REQ_PINS);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b1, 3, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b1, 1'b0, 2, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(OP_WCFG, 8'hff, 1'b1, 1'b1, SAMPLE_SLOTS, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, 1, 1'b1, IDLE_PINS);
    // config read of 0xff
    add_row(OP_RCFG, 8'h5a, 1'b0, 1'b0, 1, 1'b1, REQ_PINS);
    add_row(OP_NONE, 8'h00, 1'b1, 1'b0, 1, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h00, 1'b1, 1'b0, CFG_SLOTS, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, 1, 1'b1, IDLE_PINS);
    // config writes of both byte extremes
    add_row(OP_WCFG, 8'hff, 1'b0, 1'b0, 1, 1'b1, REQ_PINS);
    add_row(OP_NONE, 8'h00, 1'b1, 1'b0, 1, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, CFG_SLOTS + 1, 1'b0, '0);
    add_row(OP_WCFG, 8'h00, 1'b0, 1'b0, 1, 1'b1, REQ_PINS);
    add_row(OP_NONE, 8'h00, 1'b1, 1'b0, 1, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(OP_RCFG, 8'h00, 1'b1, 1'b0, CFG_SLOTS, 1'b0, '0);
    // timeout while waiting for the line to rise
    add_row(OP_SAMPLE, 8'h00, 1'b0, 1'b0, 1, 1'b1, REQ_PINS);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b1, TIMEOUT_RESET + SAMPLE_SLOTS + 1, 1'b0, '0);
    // timeout while waiting for the line to fall
    add_row(OP_RCFG, 8'h00, 1'b0, 1'b0, 1, 1'b1, REQ_PINS);
    add_row(OP_NONE, 8'h00, 1'b1, 1'b1, TIMEOUT_RESET + 2, 1'b0, '0);
    add_row(OP_NONE, 8'h00, 1'b0, 1'b0, CFG_SLOTS, 1'b0, '0);
  endtask

  task automatic run_transfer();
    int unsigned style;
    int unsigned n;
    logic [1:0]  f;
    logic [7:0]  wd;
    logic        hold;
    style = $urandom_range(0, 11);
    f     = 2'($urandom_range(1, 3));
    wd    = 8'($urandom);
    repeat ($urandom_range(0, 3))
      send_slot(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    if (style == 0) begin
      repeat ($urandom_range(5, 30))
        send_slot(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    end else begin
      send_slot(f, wd, 1'($urandom), 1'($urandom), 1'b0, '0);
      if (style <= 2 && tmo_ms <= 40) begin
        // hold the line so the wait runs out
        hold = 1'($urandom_range(0, 1));
        if (hold) send_slot(OP_NONE, 8'($urandom), 1'b1, 1'b0, 1'b0, '0);
        repeat (tmo_ms + 2) send_slot(2'($urandom), 8'($urandom), hold, 1'b1, 1'b0, '0);
      end else begin
        repeat ($urandom_range(0, 4))
          send_slot(2'($urandom), 8'($urandom), 1'b0, 1'($urandom), 1'b0, '0);
        repeat ($urandom_range(1, 4))
          send_slot(2'($urandom), 8'($urandom), 1'b1, 1'($urandom), 1'b0, '0);
        send_slot(OP_NONE, 8'($urandom), 1'b0, 1'($urandom), 1'b0, '0);
      end
      n = (f == OP_SAMPLE) ? SAMPLE_SLOTS : CFG_SLOTS;
      if (style == 3) n = $urandom_range(0, n);
      repeat (n)
        send_slot(($urandom_range(0, 7) == 0) ? 2'($urandom) : OP_NONE, 8'($urandom),
                  1'($urandom), 1'($urandom), 1'b0, '0);
    end
    if ($urandom_range(0, 11) == 0) drain_results();
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] tmo_val;
    int unsigned          set_start;
    reset_pin_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_vectors();
    foreach (vec_rows[i])
      repeat (vec_rows[i].reps)
        send_slot(vec_rows[i].func, vec_rows[i].wdata, vec_rows[i].din, vec_rows[i].tick,
                  vec_rows[i].pinned, vec_rows[i].want);
    for (int s = 0; s < 5; s++) begin
      case (s)
        0:       tmo_val = 16'd1;
        1:       tmo_val = 16'hffff;
        2:       tmo_val = 16'd3;
        3:       tmo_val = 16'($urandom_range(5, 40));
        default: tmo_val = TIMEOUT_RESET;
      endcase
      bring_to_idle();
      write_timeout(tmo_val);
      set_start = sent_slots;
      while (sent_slots - set_start < SLOTS_PER_SET) run_transfer();
    end
    drain_results();
    repeat (4) @(posedge clk_i);
    if (pending_pins.size() != 0) begin
      $error("%0d output beats never arrived", pending_pins.size());
      errors++;
    end
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
